FILE: rtl/log_binned_histogram_macros.svh
// Assertion macros for the log-binned histogram.
// Used by the top level; relies on the signals clock and reset in the including scope.
`ifndef LOG_BINNED_HISTOGRAM_MACROS_SVH
`define LOG_BINNED_HISTOGRAM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBH_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lbh_pkg.sv
// Shared types, constants and helper functions of the log-binned histogram.
// Has no dependencies; every RTL module of the design imports it.
`default_nettype none

package lbh_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_BINS   = 1024;
   localparam int DEF_COUNT_BITS = 32;

   // Field widths fixed by the interface.
   localparam int SAMPLE_W  = 32;
   localparam int SEL_W     = 10;
   localparam int OUT_CNT_W = 32;
   localparam int PADDR_W   = 4;
   localparam int PDATA_W   = 32;

   // log10(2) in Q32 and the lowest allowed log_min (-12.0 in Q16).
   localparam logic [30:0]        LOG10_2_Q32   = 31'd1292913987;
   localparam logic signed [20:0] LOG_MIN_FLOOR = -21'sd786432;

   // Register reset values.
   localparam logic signed [20:0] LOG_MIN_RST  = 21'sd0;
   localparam logic [6:0]         BPD_RST      = 7'd10;
   localparam logic [10:0]        NUM_BINS_RST = 11'd10;

   // Input command codes.
   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Normalization runs five halving steps, squaring runs sixteen.
   localparam logic [3:0] NORM_LAST = 4'd4;
   localparam logic [3:0] SQR_LAST  = 4'd15;

   typedef enum logic [1:0] {
      REG_LOG_MIN         = 2'd0,
      REG_BINS_PER_DECADE = 2'd1,
      REG_NUM_BINS        = 2'd2
   } lbh_reg_type;

   typedef struct packed {
      logic signed [20:0] log_min;
      logic [6:0]         bins_per_decade;
      logic [10:0]        num_bins;
   } lbh_cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;    // capture an accepted input item
      logic       clr_wr;  // write zero during the clearing pass
      logic       norm;    // one leading-one normalization step
      logic       sqr;     // one squaring step of the log2 fraction
      logic       logm;    // scale log2 to log10
      logic       diff;    // subtract log_min
      logic       bin;     // scale to a bin number and range check
      logic       fin;     // update the counter and load the result register
      logic [3:0] step;    // step number within norm or sqr
   } lbh_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;  // clearing pass is at its last entry
      logic rsp_busy;  // result register holds a result that is not taken
   } lbh_sts_type;

   // Shift width of each normalization step: 16, 8, 4, 2, 1.
   function automatic logic [4:0] norm_shift(input logic [2:0] step);
      logic [4:0] w;
      unique case (step)
         3'd0:    w = 5'd16;
         3'd1:    w = 5'd8;
         3'd2:    w = 5'd4;
         3'd3:    w = 5'd2;
         default: w = 5'd1;
      endcase
      return w;
   endfunction

   // Mask of the top bits tested in each normalization step.
   function automatic logic [31:0] norm_mask(input logic [2:0] step);
      logic [31:0] m;
      unique case (step)
         3'd0:    m = 32'hFFFF_0000;
         3'd1:    m = 32'hFF00_0000;
         3'd2:    m = 32'hF000_0000;
         3'd3:    m = 32'hC000_0000;
         default: m = 32'h8000_0000;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/lbh_csr.sv
// Configuration registers of the log-binned histogram behind an APB-style port.
// Depends on lbh_pkg for the register map and the configuration struct.
`default_nettype none

module lbh_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [lbh_pkg::PADDR_W-1:0]   csr_paddr,
   input  wire logic [lbh_pkg::PDATA_W-1:0]   csr_pwdata,
   output logic      [lbh_pkg::PDATA_W-1:0]   csr_prdata,
   output logic                               csr_pready,
   output lbh_pkg::lbh_cfg_type               cfg
);
   import lbh_pkg::*;

   lbh_cfg_type cfg_ff, cfg_in;
   lbh_reg_type reg_sel;
   logic        wr_en;

   assign reg_sel    = lbh_reg_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_LOG_MIN:         cfg_in.log_min         = $signed(csr_pwdata[20:0]);
            REG_BINS_PER_DECADE: cfg_in.bins_per_decade = csr_pwdata[6:0];
            REG_NUM_BINS:        cfg_in.num_bins        = csr_pwdata[10:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_LOG_MIN:         csr_prdata = {{11{cfg_ff.log_min[20]}}, cfg_ff.log_min};
         REG_BINS_PER_DECADE: csr_prdata = {25'd0, cfg_ff.bins_per_decade};
         REG_NUM_BINS:        csr_prdata = {21'd0, cfg_ff.num_bins};
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.log_min         <= LOG_MIN_RST;
         cfg_ff.bins_per_decade <= BPD_RST;
         cfg_ff.num_bins        <= NUM_BINS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/lbh_ctrl.sv
// Controller state machine of the log-binned histogram.
// Depends on lbh_pkg for the command and status structs.
`default_nettype none

module lbh_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_command,
   output logic                       req_ready,
   input  wire lbh_pkg::lbh_sts_type  sts,
   output lbh_pkg::lbh_cmd_type       cmd
);
   import lbh_pkg::*;

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_NORM  = 9'b000000100,
      ST_SQR   = 9'b000001000,
      ST_LOG   = 9'b000010000,
      ST_DIFF  = 9'b000100000,
      ST_BIN   = 9'b001000000,
      ST_RD    = 9'b010000000,
      ST_UPD   = 9'b100000000
   } lbh_state_type;

   lbh_state_type state_ff, state_in;
   logic [3:0]    step_ff, step_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.step = step_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            step_in = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_command == CMD_READ) ? ST_RD : ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.norm = 1'b1;
            if (step_ff == NORM_LAST) begin
               step_in  = '0;
               state_in = ST_SQR;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_SQR: begin
            cmd.sqr = 1'b1;
            step_in = step_ff + 4'd1;
            if (step_ff == SQR_LAST) begin
               state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            cmd.logm = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_BIN;
         end
         ST_BIN: begin
            cmd.bin  = 1'b1;
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (!sts.rsp_busy) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/lbh_dpath.sv
// Datapath of the log-binned histogram: logarithm unit, bin scaling, counter memory
// and result register. Depends on lbh_pkg; driven by commands from lbh_ctrl.
`default_nettype none

module lbh_dpath #(
   parameter int MAX_BINS   = lbh_pkg::DEF_MAX_BINS,
   parameter int COUNT_BITS = lbh_pkg::DEF_COUNT_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire lbh_pkg::lbh_cmd_type            cmd,
   output lbh_pkg::lbh_sts_type                 sts,
   input  wire lbh_pkg::lbh_cfg_type            cfg,
   input  wire logic [lbh_pkg::SAMPLE_W-1:0]    req_sample,
   input  wire logic [lbh_pkg::SEL_W-1:0]       req_bin_select,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [lbh_pkg::SEL_W-1:0]       rsp_bin_index,
   output logic                                 rsp_hit,
   output logic      [lbh_pkg::OUT_CNT_W-1:0]   rsp_count
);
   import lbh_pkg::*;

   localparam int ADDR_W = $clog2(MAX_BINS);
   localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(MAX_BINS - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Counter memory.
   logic [COUNT_BITS-1:0] mem [MAX_BINS];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_wa;
   logic [COUNT_BITS-1:0] mem_wd;

   // Logarithm and binning registers.
   logic [31:0]        y_ff, y_in;
   logic [4:0]         p_ff, p_in;
   logic [15:0]        frac_ff, frac_in;
   logic [19:0]        log_ff, log_in;
   logic signed [21:0] diff_ff, diff_in;
   logic               nonzero_ff, nonzero_in;

   // Per-item result bookkeeping.
   logic [SEL_W-1:0]   idx_ff, idx_in;
   logic               hit_ff, hit_in;
   logic               rd_ok_ff, rd_ok_in;
   logic               wr_ok_ff, wr_ok_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SEL_W-1:0]      rsp_idx_ff;
   logic                  rsp_hit_ff;
   logic [OUT_CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   // Effective configuration.
   logic [10:0]        nb_eff;
   logic [6:0]         bpd_eff;
   logic signed [20:0] lm_eff;

   // Arithmetic.
   logic [4:0]         nshift;
   logic [31:0]        nmask;
   logic [63:0]        sq_prod;
   logic [32:0]        sq_t;
   logic [51:0]        log_prod;
   logic [27:0]        bin_prod;
   logic [11:0]        bin_w;
   logic               counted;
   logic [COUNT_BITS-1:0] cnt_next;

   always_comb begin
      if (cfg.num_bins == 11'd0) begin
         nb_eff = 11'd1;
      end else if (32'(cfg.num_bins) > 32'(MAX_BINS)) begin
         nb_eff = 11'(MAX_BINS);
      end else begin
         nb_eff = cfg.num_bins;
      end
   end

   assign bpd_eff = (cfg.bins_per_decade == 7'd0) ? 7'd1 : cfg.bins_per_decade;
   assign lm_eff  = (cfg.log_min < LOG_MIN_FLOOR) ? LOG_MIN_FLOOR : cfg.log_min;

   assign nshift   = norm_shift(cmd.step[2:0]);
   assign nmask    = norm_mask(cmd.step[2:0]);
   assign sq_prod  = 64'(y_ff) * 64'(y_ff);
   assign sq_t     = sq_prod[63:31];
   assign log_prod = 52'({p_ff, frac_ff}) * 52'(LOG10_2_Q32);
   assign bin_prod = 28'(diff_ff[20:0]) * 28'(bpd_eff);
   assign bin_w    = bin_prod[27:16];
   assign counted  = nonzero_ff & ~diff_ff[21] & (bin_w < {1'b0, nb_eff});
   assign cnt_next = (rd_data_ff == COUNT_MAX) ? rd_data_ff
                                               : rd_data_ff + COUNT_BITS'(1);

   always_comb begin
      y_in       = y_ff;
      p_in       = p_ff;
      frac_in    = frac_ff;
      log_in     = log_ff;
      diff_in    = diff_ff;
      nonzero_in = nonzero_ff;
      idx_in     = idx_ff;
      hit_in     = hit_ff;
      rd_ok_in   = rd_ok_ff;
      wr_ok_in   = wr_ok_ff;
      addr_in    = addr_ff;
      if (cmd.load) begin
         y_in       = req_sample;
         p_in       = 5'd31;
         frac_in    = '0;
         nonzero_in = (req_sample != '0);
         idx_in     = req_bin_select;
         hit_in     = ({1'b0, req_bin_select} < nb_eff);
         rd_ok_in   = (32'(req_bin_select) < 32'(MAX_BINS));
         wr_ok_in   = 1'b0;
         addr_in    = ADDR_W'(req_bin_select);
      end
      if (cmd.norm) begin
         // Binary search for the leading one: shift up while the top part is empty.
         if ((y_ff & nmask) == 32'd0) begin
            y_in = y_ff << nshift;
            p_in = p_ff - nshift;
         end
      end
      if (cmd.sqr) begin
         // Squaring the mantissa doubles its log2; an overflow past 2.0 yields a one bit.
         frac_in = {frac_ff[14:0], sq_t[32]};
         y_in    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
      end
      if (cmd.logm) begin
         log_in = log_prod[51:32];
      end
      if (cmd.diff) begin
         diff_in = $signed({2'b00, log_ff}) - $signed({lm_eff[20], lm_eff});
      end
      if (cmd.bin) begin
         idx_in   = counted ? bin_w[SEL_W-1:0] : '0;
         hit_in   = counted;
         rd_ok_in = counted;
         wr_ok_in = counted;
         addr_in  = ADDR_W'(bin_w);
      end
   end

   // Memory port: the clearing pass and the counter update share the write side.
   assign mem_we = cmd.clr_wr | (cmd.fin & wr_ok_ff);
   assign mem_wa = cmd.clr_wr ? clr_addr_ff : addr_ff;
   assign mem_wd = cmd.clr_wr ? '0 : cnt_next;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[addr_ff];
   end

   assign clr_addr_in = cmd.clr_wr ? clr_addr_ff + ADDR_W'(1) : clr_addr_ff;

   always_comb begin
      if (!rd_ok_ff) begin
         rsp_cnt_in = '0;
      end else if (wr_ok_ff) begin
         rsp_cnt_in = OUT_CNT_W'(cnt_next);
      end else begin
         rsp_cnt_in = OUT_CNT_W'(rd_data_ff);
      end
   end

   always_comb begin
      if (cmd.fin) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      y_ff       <= y_in;
      p_ff       <= p_in;
      frac_ff    <= frac_in;
      log_ff     <= log_in;
      diff_ff    <= diff_in;
      nonzero_ff <= nonzero_in;
      idx_ff     <= idx_in;
      hit_ff     <= hit_in;
      rd_ok_ff   <= rd_ok_in;
      wr_ok_ff   <= wr_ok_in;
      addr_ff    <= addr_in;
      if (cmd.fin) begin
         rsp_idx_ff <= idx_ff;
         rsp_hit_ff <= hit_ff;
         rsp_cnt_ff <= rsp_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.clr_last   = (clr_addr_ff == LAST_ADDR);
   assign sts.rsp_busy   = rsp_valid_ff & ~rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bin_index  = rsp_idx_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_count      = rsp_cnt_ff;

endmodule

`default_nettype wire

FILE: rtl/log_binned_histogram.sv
// Top level of the log-binned histogram: configuration registers, controller and datapath.
// Depends on lbh_pkg, lbh_csr, lbh_ctrl, lbh_dpath and log_binned_histogram_macros.svh.
//
//   Port group   Direction   Transfer condition                          Carries
//   req_*        in          req_valid & req_ready                       command, sample, bin
//   rsp_*        out         rsp_valid & rsp_ready                       bin, hit, count
//   csr_*        in/out      csr_psel & csr_penable & csr_pwrite         register writes
//
// An add item presents its result after five leading-one search steps, sixteen squaring steps
// on one 32x32 multiplier, then scaling, binning and the counter access.
// A read item presents its result once its counter is read. One item is in work at a time;
// the next transfer can be taken as soon as the result is loaded.
// After reset a clearing pass zeroes all MAX_BINS counters with req_ready low.
// A waiting result holds back only the final counter update of the next item.
`default_nettype none

`include "log_binned_histogram_macros.svh"

module log_binned_histogram #(
   parameter int MAX_BINS   = lbh_pkg::DEF_MAX_BINS,
   parameter int COUNT_BITS = lbh_pkg::DEF_COUNT_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Input channel.
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_command,
   input  wire logic [lbh_pkg::SAMPLE_W-1:0]    req_sample,
   input  wire logic [lbh_pkg::SEL_W-1:0]       req_bin_select,
   // Result channel.
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [lbh_pkg::SEL_W-1:0]       rsp_bin_index,
   output logic                                 rsp_hit,
   output logic      [lbh_pkg::OUT_CNT_W-1:0]   rsp_count,
   // Configuration port.
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [lbh_pkg::PADDR_W-1:0]     csr_paddr,
   input  wire logic [lbh_pkg::PDATA_W-1:0]     csr_pwdata,
   output logic      [lbh_pkg::PDATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);
   import lbh_pkg::*;

   // The controller and datapath talk only through these two structs.
   lbh_cfg_type cfg;
   lbh_cmd_type cmd;
   lbh_sts_type sts;

   // The three registers hold the raw written values; the datapath applies the
   // clamping of log_min, bins_per_decade and num_bins when it uses them.
   lbh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The controller sequences each item: accept, then for an add normalize, square, scale,
   // subtract and bin; read the counter; write it back if counted while loading the result.
   lbh_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   // The datapath holds the counter memory, with registered read data, and the
   // shared multiplier steps of the logarithm.
   lbh_dpath #(
      .MAX_BINS   (MAX_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .cfg            (cfg),
      .req_sample     (req_sample),
      .req_bin_select (req_bin_select),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bin_index  (rsp_bin_index),
      .rsp_hit        (rsp_hit),
      .rsp_count      (rsp_count)
   );

   // After an input transfer the block is busy with that item in the next cycle.
   `LBH_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready after transfer")
   // Finishing an item always presents a result in the next cycle.
   `LBH_ASSERT_NEXT(a_fin_gives_rsp, cmd.fin, rsp_valid, "finished item gave no result")
   // No item is taken while the clearing pass still writes the memory.
   `LBH_ASSERT_SAME(a_no_req_in_clear, cmd.clr_wr, !req_ready, "input taken during clear")
   // A result that waits for the consumer is never overwritten.
   `LBH_ASSERT_SAME(a_no_overwrite, rsp_valid && !rsp_ready, !cmd.fin, "waiting result lost")

endmodule

`default_nettype wire
